[hw/rtl/krf_pkg.sv]
// Package for the keyed record FIFO: types, sizes, opcodes, state codes.
package krf_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned NumClasses = 5;
  localparam int unsigned FirstYear  = 5;
  localparam int unsigned IdxW   = $clog2(QueueDepth);
  localparam int unsigned CntW   = $clog2(QueueDepth + 1);
  localparam int unsigned ClassW = $clog2(NumClasses);
  localparam int unsigned ClassDepth = NumClasses * QueueDepth;
  localparam int unsigned ClassAddrW = $clog2(ClassDepth);

  typedef enum logic [1:0] {
    KindEnqueue    = 2'd0,
    KindRemove     = 2'd1,
    KindDistribute = 2'd2,
    KindReadout    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    StatOk       = 3'd0,
    StatEmpty    = 3'd1,
    StatFull     = 3'd2,
    StatNotFound = 3'd3,
    StatDropped  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    StIdle,
    StRemove,
    StDist,
    StReadMain,
    StReadClass,
    StRespond
  } state_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] student_id;
    logic [63:0]        name_head;
    logic [15:0]        name_tail;
    logic [7:0]         age;
    logic [3:0]         school_year;
    logic [2:0]         queue_select;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] student_id_res;
    logic [63:0]        name_head_res;
    logic [15:0]        name_tail_res;
    logic [7:0]         age_res;
    logic [3:0]         school_year_res;
    logic [4:0]         count;
    logic               last;
  } res_t;

  // controller -> datapath
  typedef struct packed {
    logic load_req;   // latch incoming request
    logic enqueue;    // do enqueue and form its result
    logic clr_walk;   // reset walk pointers
    logic rm_step;    // one compaction step
    logic dist_step;  // one distribute step
    logic rd_step;    // read one entry, stage a result
    logic fin_simple; // form single result (remove/distribute/empty readout)
    logic out_pop;    // output register consumed
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic walk_done;  // pointer reached the fill level
    logic src_empty;  // selected readout source is empty/invalid
    logic main_empty;
    logic out_full;
    logic rd_pend;    // read data in flight
  } stat_t;

endpackage

[hw/rtl/krf_ctrl.sv]
// Controller for the keyed record FIFO: sequences one request at a time.
module krf_ctrl import krf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  logic [1:0] kind_i,
  input  logic  out_stall_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != StIdle) || stat_i.out_full;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (kind_e'(kind_i))
            KindEnqueue:    state_d = StIdle;
            KindRemove:     state_d = StRemove;
            KindDistribute: state_d = StDist;
            KindReadout:    state_d = StReadMain;
            default:        state_d = StIdle;
          endcase
        end
      end
      StRemove: if (stat_i.walk_done) state_d = StRespond;
      StDist:   if (stat_i.walk_done) state_d = StRespond;
      // readout decision state once the request is latched
      StReadMain: state_d = stat_i.src_empty ? StRespond : StReadClass;
      StReadClass: begin
        if (stat_i.walk_done && !stat_i.rd_pend && !stat_i.out_full) state_d = StIdle;
      end
      StRespond: if (!stat_i.out_full) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.out_pop = !out_stall_i;
    unique case (state_q)
      StIdle: begin
        cmd_o.load_req = accept;
        cmd_o.clr_walk = accept;
        cmd_o.enqueue  = accept && (kind_e'(kind_i) == KindEnqueue);
      end
      StRemove:    cmd_o.rm_step   = !stat_i.walk_done;
      StDist:      cmd_o.dist_step = !stat_i.walk_done;
      StReadMain:  ;
      StReadClass: cmd_o.rd_step   = 1'b1;
      StRespond:   cmd_o.fin_simple = !stat_i.out_full;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hw/rtl/krf_datapath.sv]
// Datapath for the keyed record FIFO: stores, walk pointers, result register.
module krf_datapath import krf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  req_t  req_i,
  input  cmd_t  cmd_i,
  output stat_t stat_o,
  output logic  out_valid_o,
  output res_t  res_o
);

  // main queue stores
  logic [31:0] m_id   [QueueDepth];
  logic [63:0] m_name [QueueDepth];
  logic [15:0] m_tail [QueueDepth];
  logic [7:0]  m_age  [QueueDepth];
  logic [3:0]  m_year [QueueDepth];
  // class stores
  logic [31:0] c_id   [ClassDepth];
  logic [63:0] c_name [ClassDepth];
  logic [15:0] c_tail [ClassDepth];
  logic [7:0]  c_age  [ClassDepth];

  logic [CntW-1:0] main_cnt_q;
  logic [CntW-1:0] cls_cnt_q [NumClasses];
  req_t            req_q;
  logic [CntW-1:0] rd_q, wr_q, tally_q;
  logic            dropped_q;
  res_t            res_q, res_d;
  logic            out_valid_q, out_valid_d;

  // registered read stage: one memory read per cycle while the output slot can take data
  logic            rv_q;
  logic [IdxW-1:0] rpos_q;
  logic [31:0]     r_id_q;
  logic [63:0]     r_name_q;
  logic [15:0]     r_tail_q;
  logic [7:0]      r_age_q;
  logic [3:0]      r_year_q;

  logic [CntW-1:0]   lim;
  logic              sel_main, sel_cls_ok;
  logic [ClassW-1:0] sel_q_idx;
  logic [ClassW-1:0] yq;
  logic              y_in;
  logic [ClassAddrW-1:0] slot, raddr;
  logic              can_issue, out_free;

  assign sel_main   = (req_q.queue_select == 3'd0);
  assign sel_cls_ok = (req_q.queue_select != 3'd0) &&
                      ({1'b0, req_q.queue_select} <= 4'(NumClasses));
  assign sel_q_idx  = ClassW'(req_q.queue_select - 3'd1);
  assign lim = sel_main ? main_cnt_q : (sel_cls_ok ? cls_cnt_q[sel_q_idx] : '0);

  assign y_in = ({1'b0, m_year[rd_q[IdxW-1:0]]} >= 5'(FirstYear)) &&
                ({1'b0, m_year[rd_q[IdxW-1:0]]} < 5'(FirstYear + NumClasses));
  assign yq   = ClassW'(m_year[rd_q[IdxW-1:0]] - 4'(FirstYear));
  assign slot = ClassAddrW'(yq * QueueDepth) + ClassAddrW'(cls_cnt_q[yq]);
  assign raddr = ClassAddrW'(sel_q_idx * QueueDepth) + ClassAddrW'(rd_q);

  assign out_free  = !out_valid_q || cmd_i.out_pop;
  // issue a read only when the read stage is empty or its data can move to the output slot
  assign can_issue = cmd_i.rd_step && (rd_q < lim) && (!rv_q || out_free);

  always_comb begin
    stat_o = '0;
    stat_o.walk_done  = cmd_i.rd_step ? (rd_q >= lim) : (rd_q >= main_cnt_q);
    stat_o.src_empty  = (lim == '0);
    stat_o.main_empty = (main_cnt_q == '0);
    stat_o.out_full   = !out_free;
    stat_o.rd_pend    = rv_q;
  end

  // result register next value
  always_comb begin
    res_d       = res_q;
    out_valid_d = out_valid_q && !cmd_i.out_pop;
    if (cmd_i.enqueue) begin
      res_d      = '0;
      res_d.last = 1'b1;
      if (main_cnt_q < CntW'(QueueDepth)) begin
        res_d.status = StatOk;
        res_d.count  = 5'(main_cnt_q + 1'b1);
      end else begin
        res_d.status = StatFull;
        res_d.count  = 5'(main_cnt_q);
      end
      out_valid_d = 1'b1;
    end
    if (cmd_i.rd_step && rv_q && out_free) begin
      res_d.status          = StatOk;
      res_d.student_id_res  = r_id_q;
      res_d.name_head_res   = r_name_q;
      res_d.name_tail_res   = r_tail_q;
      res_d.age_res         = r_age_q;
      res_d.school_year_res = r_year_q;
      res_d.count           = 5'(rpos_q);
      res_d.last            = (CntW'(rpos_q) + 1'b1 == lim);
      out_valid_d           = 1'b1;
    end
    if (cmd_i.fin_simple) begin
      res_d       = '0;
      res_d.last  = 1'b1;
      out_valid_d = 1'b1;
      unique case (kind_e'(req_q.kind))
        KindRemove: begin
          res_d.status = (tally_q == '0) ? StatNotFound : StatOk;
          res_d.count  = 5'(tally_q);
        end
        KindDistribute: begin
          if (main_cnt_q == '0) res_d.status = StatEmpty;
          else res_d.status = dropped_q ? StatDropped : StatOk;
          res_d.count = 5'(tally_q);
        end
        default: res_d.status = StatEmpty;
      endcase
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.enqueue && main_cnt_q < CntW'(QueueDepth)) begin
      m_id[main_cnt_q[IdxW-1:0]]   <= req_i.student_id;
      m_name[main_cnt_q[IdxW-1:0]] <= req_i.name_head;
      m_tail[main_cnt_q[IdxW-1:0]] <= req_i.name_tail;
      m_age[main_cnt_q[IdxW-1:0]]  <= req_i.age;
      m_year[main_cnt_q[IdxW-1:0]] <= req_i.school_year;
    end else if (cmd_i.rm_step && m_id[rd_q[IdxW-1:0]] != req_q.student_id) begin
      m_id[wr_q[IdxW-1:0]]   <= m_id[rd_q[IdxW-1:0]];
      m_name[wr_q[IdxW-1:0]] <= m_name[rd_q[IdxW-1:0]];
      m_tail[wr_q[IdxW-1:0]] <= m_tail[rd_q[IdxW-1:0]];
      m_age[wr_q[IdxW-1:0]]  <= m_age[rd_q[IdxW-1:0]];
      m_year[wr_q[IdxW-1:0]] <= m_year[rd_q[IdxW-1:0]];
    end
    if (cmd_i.dist_step && y_in && cls_cnt_q[yq] < CntW'(QueueDepth)) begin
      c_id[slot]   <= m_id[rd_q[IdxW-1:0]];
      c_name[slot] <= m_name[rd_q[IdxW-1:0]];
      c_tail[slot] <= m_tail[rd_q[IdxW-1:0]];
      c_age[slot]  <= m_age[rd_q[IdxW-1:0]];
    end
    if (can_issue) begin
      if (sel_main) begin
        r_id_q   <= m_id[rd_q[IdxW-1:0]];
        r_name_q <= m_name[rd_q[IdxW-1:0]];
        r_tail_q <= m_tail[rd_q[IdxW-1:0]];
        r_age_q  <= m_age[rd_q[IdxW-1:0]];
        r_year_q <= m_year[rd_q[IdxW-1:0]];
      end else begin
        r_id_q   <= c_id[raddr];
        r_name_q <= c_name[raddr];
        r_tail_q <= c_tail[raddr];
        r_age_q  <= c_age[raddr];
        r_year_q <= 4'(sel_q_idx) + 4'(FirstYear);
      end
      rpos_q <= rd_q[IdxW-1:0];
    end
    if (cmd_i.load_req) req_q <= req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_cnt_q  <= '0;
      for (int k = 0; k < NumClasses; k++) cls_cnt_q[k] <= '0;
      rd_q        <= '0;
      wr_q        <= '0;
      tally_q     <= '0;
      dropped_q   <= 1'b0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      res_q       <= res_d;
      if (cmd_i.clr_walk) begin
        rd_q <= '0; wr_q <= '0; tally_q <= '0; dropped_q <= 1'b0;
      end
      if (cmd_i.enqueue && main_cnt_q < CntW'(QueueDepth)) begin
        main_cnt_q <= main_cnt_q + 1'b1;
      end
      if (cmd_i.rm_step) begin
        rd_q <= rd_q + 1'b1;
        if (m_id[rd_q[IdxW-1:0]] == req_q.student_id) tally_q <= tally_q + 1'b1;
        else wr_q <= wr_q + 1'b1;
      end
      if (cmd_i.dist_step) begin
        rd_q <= rd_q + 1'b1;
        if (y_in) begin
          if (cls_cnt_q[yq] < CntW'(QueueDepth)) begin
            cls_cnt_q[yq] <= cls_cnt_q[yq] + 1'b1;
            tally_q <= tally_q + 1'b1;
          end else begin
            dropped_q <= 1'b1;
          end
        end
      end
      if (can_issue) rd_q <= rd_q + 1'b1;
      if (cmd_i.rd_step) begin
        if (rv_q && out_free) begin
          rv_q <= can_issue;
        end else if (can_issue) begin
          rv_q <= 1'b1;
        end
      end
      if (cmd_i.fin_simple) begin
        if (kind_e'(req_q.kind) == KindRemove) main_cnt_q <= wr_q;
        else if (kind_e'(req_q.kind) == KindDistribute) main_cnt_q <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

[hw/rtl/keyed_record_fifo_with_class_split.sv]
// Top level of the keyed record FIFO with class split.
// One request at a time. Enqueue is performed on acceptance; remove and distribute walk
// the main queue one entry per cycle; readout streams one record per cycle from the
// selected queue while the output register is not stalled.
// Results leave through one output register that is held while out_stall_i is high.
module keyed_record_fifo_with_class_split import krf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output res_t out_res_o
);

  cmd_t  cmd;
  stat_t stat;

  krf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (in_req_i.kind),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  krf_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (in_req_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .res_o       (out_res_o)
  );

endmodule

[sim/krf_checker.sv]
// Checker for the keyed record FIFO: watches both channels, predicts results, compares.
`timescale 1ns / 100ps
module krf_checker import krf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_i,
  input  req_t in_req_i,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  res_t out_res_i,
  output int   err_cnt_o,
  output int   pending_o
);

  typedef struct packed {
    logic signed [31:0] id;
    logic [63:0]        nh;
    logic [15:0]        nt;
    logic [7:0]         age;
    logic [3:0]         year;
  } rec_t;

  rec_t   main_q[$];
  rec_t   class_q[NumClasses][$];
  res_t   expected_q[$];

  assign pending_o = expected_q.size();

  function automatic res_t simple_res(status_e st, int cnt);
    res_t r;
    r = '0;
    r.status = st;
    r.count = cnt[4:0];
    r.last = 1'b1;
    return r;
  endfunction

  task automatic predict_request(req_t rq);
    rec_t rc;
    res_t r;
    rec_t keep[$];
    int removed, moved, q, sel;
    bit dropped;
    case (kind_e'(rq.kind))
      KindEnqueue: begin
        if (main_q.size() >= QueueDepth) begin
          expected_q.push_back(simple_res(StatFull, main_q.size()));
        end else begin
          rc = '{rq.student_id, rq.name_head, rq.name_tail, rq.age, rq.school_year};
          main_q.push_back(rc);
          expected_q.push_back(simple_res(StatOk, main_q.size()));
        end
      end
      KindRemove: begin
        removed = 0;
        foreach (main_q[i]) begin
          if (main_q[i].id == rq.student_id) removed++;
          else keep.push_back(main_q[i]);
        end
        main_q = keep;
        expected_q.push_back(simple_res(removed ? StatOk : StatNotFound, removed));
      end
      KindDistribute: begin
        if (main_q.size() == 0) begin
          expected_q.push_back(simple_res(StatEmpty, 0));
        end else begin
          moved = 0;
          dropped = 0;
          foreach (main_q[i]) begin
            if (main_q[i].year >= FirstYear && main_q[i].year < FirstYear + NumClasses) begin
              q = main_q[i].year - FirstYear;
              if (class_q[q].size() >= QueueDepth) dropped = 1;
              else begin
                class_q[q].push_back(main_q[i]);
                moved++;
              end
            end
          end
          main_q.delete();
          expected_q.push_back(simple_res(dropped ? StatDropped : StatOk, moved));
        end
      end
      default: begin
        sel = rq.queue_select;
        if (sel == 0) keep = main_q;
        else if (sel <= NumClasses) keep = class_q[sel-1];
        if (keep.size() == 0) begin
          expected_q.push_back(simple_res(StatEmpty, 0));
        end else begin
          foreach (keep[i]) begin
            r = '0;
            r.status = StatOk;
            r.student_id_res = keep[i].id;
            r.name_head_res = keep[i].nh;
            r.name_tail_res = keep[i].nt;
            r.age_res = keep[i].age;
            r.school_year_res = (sel == 0) ? keep[i].year : 4'(FirstYear + sel - 1);
            r.count = i[4:0];
            r.last = (i == keep.size() - 1);
            expected_q.push_back(r);
          end
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t exp_r;
    if (!rst_ni) begin
      err_cnt_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) predict_request(in_req_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_res_i);
          err_cnt_o <= err_cnt_o + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r !== out_res_i) begin
            $display("%0t: mismatch expected %p actual %p", $time, exp_r, out_res_i);
            err_cnt_o <= err_cnt_o + 1;
          end
        end
      end
    end
  end

endmodule

[sim/keyed_record_fifo_with_class_split_test.sv]
// Testbench top: stimulus, clock, reset and verdict for the keyed record FIFO.
`timescale 1ns / 100ps
module keyed_record_fifo_with_class_split_test;
  import krf_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_stall_o;
  req_t in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 0;
  res_t out_res_o;
  int   err_cnt, pending;

  logic signed [31:0] id_pool[4];

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  keyed_record_fifo_with_class_split u_dut (.*);

  krf_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_req_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_res_i(out_res_o),
    .err_cnt_o(err_cnt), .pending_o(pending)
  );

  // receiver stall pattern: alternating calm and busy stretches
  always @(posedge clk_i) begin
    int phase;
    phase = int'(($time / 4000) % 3);
    if (phase == 0) out_stall_i <= 1'b0;
    else if (phase == 1) out_stall_i <= ($urandom_range(3) == 0);
    else out_stall_i <= ($urandom_range(1) == 0);
  end

  function automatic req_t rand_request(kind_e k);
    req_t r;
    r.kind = k;
    r.student_id = ($urandom_range(3) != 0) ? id_pool[$urandom_range(3)] : $urandom;
    r.name_head = {$urandom, $urandom};
    r.name_tail = 16'($urandom);
    r.age = 8'($urandom);
    r.school_year = ($urandom_range(4) != 0) ? 4'($urandom_range(9, 5))
                                             : 4'($urandom_range(15));
    r.queue_select = ($urandom_range(7) != 0) ? 3'($urandom_range(5))
                                              : 3'($urandom_range(7));
    return r;
  endfunction

  // drive one request and hold it until accepted; leaves valid high
  task automatic send(req_t r);
    in_valid_i <= 1'b1;
    in_req_i <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  initial begin
    req_t r;
    int k, burst;
    id_pool = '{32'sh7fffffff, 32'sh80000000, 0, -1};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: empty cases, extremes, overflow of the main queue
    send(rand_request(KindDistribute));
    r = rand_request(KindRemove); r.student_id = 5; send(r);
    for (int s = 0; s < 8; s++) begin
      r = rand_request(KindReadout); r.queue_select = 3'(s); send(r);
    end
    r = '0; r.kind = KindEnqueue; r.school_year = 4'd5; send(r);
    r.student_id = 32'sh80000000; r.name_head = '1; r.name_tail = '1; r.age = '1;
    r.school_year = 4'hf; send(r);
    for (int i = 0; i < 15; i++) begin
      r = rand_request(KindEnqueue); r.school_year = 4'd7; send(r);
    end
    r = rand_request(KindReadout); r.queue_select = 0; send(r);
    send(rand_request(KindDistribute));
    // random: mostly fill/remove/distribute/readout sequences
    k = 0;
    while (k < 120) begin
      burst = $urandom_range(8, 1);
      repeat (burst) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4: r = rand_request(KindEnqueue);
          5, 6: r = rand_request(KindRemove);
          7: r = rand_request(KindDistribute);
          default: r = rand_request(KindReadout);
        endcase
        send(r);
        k++;
      end
      pause(($urandom_range(3) == 0) ? 0 : $urandom_range(6));
    end
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (err_cnt == 0) $display("keyed_record_fifo_with_class_split_test: clean");
    else $display("keyed_record_fifo_with_class_split_test: errors");
    $finish;
  end

  initial begin
    #2ms;
    $display("keyed_record_fifo_with_class_split_test: errors");
    $finish;
  end

endmodule
